/* sv/scs_pkg.sv */
// shared types, constants and codes of the scrolling strip chart engine
package scs_pkg;

	// store depth and field widths
	localparam int STORE_DEPTH_DEF = 64;
	localparam int VAL_W           = 32;
	localparam int PIX_W           = 11;
	localparam int ROW_W           = 12;
	localparam int CNT_W           = 7;
	localparam int IDX_W           = 3;
	localparam int OP_W            = 2;
	// divider operands: scaled sample product and sample range
	localparam int NUM_W           = 45;
	localparam int DEN_W           = 33;
	// stream payload widths
	localparam int IN_DATA_W       = 2 * VAL_W;
	localparam int OUT_DATA_W      = 4 * ROW_W + VAL_W;

	// operation codes carried in tuser
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_INIT = 2'd0;
	localparam op_t OP_PUSH = 2'd1;
	localparam op_t OP_DRAW = 2'd2;

	// configuration register indexes
	typedef logic [IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_VALUE    = 3'd0;
	localparam cfg_idx_t CFG_MAX_VALUE    = 3'd1;
	localparam cfg_idx_t CFG_PLOT_LEFT    = 3'd2;
	localparam cfg_idx_t CFG_PLOT_TOP     = 3'd3;
	localparam cfg_idx_t CFG_PLOT_WIDTH   = 3'd4;
	localparam cfg_idx_t CFG_PLOT_HEIGHT  = 3'd5;
	localparam cfg_idx_t CFG_SAMPLE_COUNT = 3'd6;

	// configuration reset values
	localparam logic [VAL_W-1:0] RST_MIN_VALUE    = 32'd0;
	localparam logic [VAL_W-1:0] RST_MAX_VALUE    = 32'd100;
	localparam logic [PIX_W-1:0] RST_PLOT_LEFT    = 11'd0;
	localparam logic [PIX_W-1:0] RST_PLOT_TOP     = 11'd0;
	localparam logic [PIX_W-1:0] RST_PLOT_WIDTH   = 11'd320;
	localparam logic [PIX_W-1:0] RST_PLOT_HEIGHT  = 11'd240;
	localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = 7'd64;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_PMUL,
		S_PDIVS,
		S_PDIV,
		S_PWR,
		S_DDIVS,
		S_DDIV,
		S_DSET,
		S_DRD,
		S_DOUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic latch_in;
		logic fill_clr;
		logic fill_wr;
		logic init_done;
		logic mul;
		logic div_start;
		logic div_draw;
		logic push_wr;
		logic draw_setup;
		logic rd_newest;
		logic rd_step;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic ready;
		logic fill_last;
		logic div_busy;
		logic out_free;
		logic seg_last;
		logic range_zero;
	} stat_t;

endpackage

/* sv/scs_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module scs_div #(
	parameter int NW = scs_pkg::NUM_W,
	parameter int DW = scs_pkg::DEN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW:0]     trial_w;
	logic [DW:0]     diff_w;
	logic            ge_w;

	// shift in the next numerator bit and try the subtraction
	assign trial_w = {rem_q, quo_q[NW-1]};
	assign diff_w  = trial_w - {1'b0, den_q};
	assign ge_w    = trial_w >= {1'b0, den_q};

	// step count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(NW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge_w};
			rem_q <= ge_w ? diff_w[DW-1:0] : trial_w[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* sv/scs_dp.sv */
// datapath: configuration, row store, sample scaling and segment generation
module scs_dp #(
	parameter int STORE_DEPTH = scs_pkg::STORE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [scs_pkg::IDX_W-1:0]        cfg_index,
	input  logic [scs_pkg::VAL_W-1:0]        cfg_data,
	input  logic [scs_pkg::IN_DATA_W-1:0]    s_tdata,
	input  scs_pkg::cmd_t                    cmd,
	output scs_pkg::stat_t                   st,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [scs_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int VW = scs_pkg::VAL_W;
	localparam int PW = scs_pkg::PIX_W;
	localparam int RW = scs_pkg::ROW_W;
	localparam int NW = scs_pkg::NUM_W;
	localparam int DW = scs_pkg::DEN_W;

	// configuration registers
	logic [VW-1:0]             min_q;
	logic [VW-1:0]             max_q;
	logic [PW-1:0]             left_q;
	logic [PW-1:0]             top_q;
	logic [PW-1:0]             width_q;
	logic [PW-1:0]             height_q;
	logic [scs_pkg::CNT_W-1:0] count_q;

	// item payload
	logic [VW-1:0] sample_q;
	logic [VW-1:0] color_q;

	// control state
	logic [AW-1:0] fill_q;
	logic [AW-1:0] wslot_q;
	logic [AW-1:0] newest_q;
	logic          ready_q;
	logic [AW-1:0] cur_q;
	logic [CW-1:0] cnt_q;
	logic          m_tvalid_q;

	// datapath registers
	logic [NW-1:0] prod_q;
	logic [DW-1:0] r_q;
	logic [PW-1:0] wq_q;
	logic [CW-1:0] wr_q;
	logic [PW-1:0] xq_q;
	logic [CW-1:0] xr_q;
	logic [RW-1:0] rdata_q;
	logic [RW-1:0] y0_q;
	logic [RW-1:0] row_store_q [STORE_DEPTH];

	// output register
	logic [RW-1:0] xs_q;
	logic [RW-1:0] ys_q;
	logic [RW-1:0] xe_q;
	logic [RW-1:0] ye_q;
	logic [VW-1:0] oc_q;
	logic          olast_q;

	logic [CW-1:0]        n_w;
	logic [CW-1:0]        nm1_full_w;
	logic [AW-1:0]        nm1_w;
	logic [RW-1:0]        bottom_w;
	logic signed [DW-1:0] d_w;
	logic signed [DW-1:0] range_w;
	logic signed [PW:0]   h_w;
	logic signed [NW-1:0] prod_w;
	logic [NW-1:0]        pmag_w;
	logic [DW-1:0]        rmag_w;
	logic [NW-1:0]        div_num_w;
	logic [DW-1:0]        div_den_w;
	logic                 div_busy_w;
	logic [NW-1:0]        quo_w;
	logic [DW-1:0]        rem_w;
	logic                 neg_w;
	logic [RW-1:0]        row_w;
	logic [CW-1:0]        wsum_w;
	logic [AW-1:0]        wnext_w;
	logic [AW-1:0]        prev_w;
	logic                 we_w;
	logic [AW-1:0]        waddr_w;
	logic [RW-1:0]        wdata_w;
	logic                 re_w;
	logic [AW-1:0]        raddr_w;
	logic [RW-1:0]        xsum_w;
	logic [CW:0]          rsum_w;
	logic                 carry_w;
	logic [CW-1:0]        xr_next_w;
	logic                 out_free_w;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= scs_pkg::RST_MIN_VALUE;
			max_q    <= scs_pkg::RST_MAX_VALUE;
			left_q   <= scs_pkg::RST_PLOT_LEFT;
			top_q    <= scs_pkg::RST_PLOT_TOP;
			width_q  <= scs_pkg::RST_PLOT_WIDTH;
			height_q <= scs_pkg::RST_PLOT_HEIGHT;
			count_q  <= scs_pkg::RST_SAMPLE_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				scs_pkg::CFG_MIN_VALUE:    min_q    <= cfg_data;
				scs_pkg::CFG_MAX_VALUE:    max_q    <= cfg_data;
				scs_pkg::CFG_PLOT_LEFT:    left_q   <= cfg_data[PW-1:0];
				scs_pkg::CFG_PLOT_TOP:     top_q    <= cfg_data[PW-1:0];
				scs_pkg::CFG_PLOT_WIDTH:   width_q  <= cfg_data[PW-1:0];
				scs_pkg::CFG_PLOT_HEIGHT:  height_q <= cfg_data[PW-1:0];
				scs_pkg::CFG_SAMPLE_COUNT: count_q  <= cfg_data[scs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// active count held to at least 2 and saturated to the store depth
	always_comb begin
		if (count_q < scs_pkg::CNT_W'(2)) begin
			n_w = CW'(2);
		end else if (count_q > scs_pkg::CNT_W'(STORE_DEPTH)) begin
			n_w = CW'(STORE_DEPTH);
		end else begin
			n_w = CW'(count_q);
		end
	end

	assign nm1_full_w = n_w - CW'(1);
	assign nm1_w      = nm1_full_w[AW-1:0];
	assign bottom_w   = {1'b0, top_q} + {1'b0, height_q};

	// latch the item payload on acceptance
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			sample_q <= s_tdata[VW-1:0];
			color_q  <= s_tdata[2*VW-1:VW];
		end
	end

	// offset from the bottom value times plot height
	assign d_w     = $signed({sample_q[VW-1], sample_q}) - $signed({min_q[VW-1], min_q});
	assign range_w = $signed({max_q[VW-1], max_q}) - $signed({min_q[VW-1], min_q});
	assign h_w     = $signed({1'b0, height_q});
	assign prod_w  = d_w * h_w;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_w;
			r_q    <= range_w;
		end
	end

	// magnitudes for the shared divider
	assign pmag_w = prod_q[NW-1] ? (~prod_q + NW'(1)) : prod_q;
	assign rmag_w = r_q[DW-1] ? (~r_q + DW'(1)) : r_q;

	assign div_num_w = cmd.div_draw ? NW'(width_q) : pmag_w;
	assign div_den_w = cmd.div_draw ? DW'(n_w) : rmag_w;

	scs_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num_w),
		.den   (div_den_w),
		.busy  (div_busy_w),
		.quo   (quo_w),
		.rem   (rem_w)
	);

	// row from the truncated quotient, clamped to the plot area
	assign neg_w = prod_q[NW-1] ^ r_q[DW-1];

	always_comb begin
		if ((r_q == '0) || neg_w) begin
			row_w = bottom_w;
		end else if (quo_w > NW'(height_q)) begin
			row_w = {1'b0, top_q};
		end else begin
			row_w = bottom_w - quo_w[RW-1:0];
		end
	end

	// slot stepping with wrap at the active count
	assign wsum_w  = CW'(wslot_q) + CW'(1);
	assign wnext_w = (wsum_w >= n_w) ? '0 : wsum_w[AW-1:0];
	assign prev_w  = (cur_q == '0) ? nm1_w : cur_q - AW'(1);

	// row store port
	assign we_w    = cmd.fill_wr | cmd.push_wr;
	assign waddr_w = cmd.fill_wr ? fill_q : wslot_q;
	assign wdata_w = cmd.fill_wr ? bottom_w : row_w;
	assign re_w    = cmd.rd_newest | cmd.rd_step;
	assign raddr_w = cmd.rd_newest ? newest_q : prev_w;

	always_ff @(posedge clk) begin
		if (we_w) begin
			row_store_q[waddr_w] <= wdata_w;
		end
		if (re_w) begin
			rdata_q <= row_store_q[raddr_w];
		end
	end

	// column stepping: quotient and remainder of i*width/n kept incrementally
	assign xsum_w    = {1'b0, xq_q} + {1'b0, wq_q} + RW'(carry_w);
	assign rsum_w    = {1'b0, xr_q} + {1'b0, wr_q};
	assign carry_w   = rsum_w >= {1'b0, n_w};
	assign xr_next_w = carry_w ? CW'(rsum_w - {1'b0, n_w}) : rsum_w[CW-1:0];

	assign out_free_w = !m_tvalid_q || m_tready;

	// pointers, flags and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			wslot_q    <= '0;
			newest_q   <= '0;
			ready_q    <= 1'b0;
			cur_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.fill_wr) begin
				fill_q <= fill_q + AW'(1);
			end
			if (cmd.init_done) begin
				wslot_q  <= '0;
				newest_q <= '0;
				ready_q  <= 1'b1;
			end else if (cmd.push_wr) begin
				newest_q <= wslot_q;
				wslot_q  <= wnext_w;
			end
			if (cmd.draw_setup) begin
				cur_q <= newest_q;
				cnt_q <= nm1_full_w;
			end else begin
				if (cmd.rd_step) begin
					cur_q <= prev_w;
				end
				if (cmd.load_out) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// draw run registers and output payload
	always_ff @(posedge clk) begin
		if (cmd.draw_setup) begin
			wq_q <= quo_w[PW-1:0];
			wr_q <= rem_w[CW-1:0];
			xq_q <= '0;
			xr_q <= '0;
		end else if (cmd.load_out) begin
			xq_q <= xsum_w[PW-1:0];
			xr_q <= xr_next_w;
		end
		if (cmd.rd_step) begin
			y0_q <= rdata_q;
		end
		if (cmd.load_out) begin
			xs_q    <= {1'b0, left_q} + {1'b0, xq_q};
			ys_q    <= y0_q;
			xe_q    <= {1'b0, left_q} + xsum_w;
			ye_q    <= rdata_q;
			oc_q    <= color_q;
			olast_q <= (cnt_q == CW'(1));
		end
	end

	// status to the controller
	assign st.ready      = ready_q;
	assign st.fill_last  = (fill_q == nm1_w);
	assign st.div_busy   = div_busy_w;
	assign st.out_free   = out_free_w;
	assign st.seg_last   = (cnt_q == CW'(1));
	assign st.range_zero = (max_q == min_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {oc_q, ye_q, xe_q, ys_q, xs_q};
	assign m_tlast  = olast_q;

	// a segment is loaded only into a free output register, and then shown
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free_w)
		else $error("segment loaded over a pending transaction");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid_q)
		else $error("loaded segment not offered");

	a_seg_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (cnt_q != '0))
		else $error("segment emitted beyond the run");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> ((row_w >= {1'b0, top_q}) && (row_w <= bottom_w)))
		else $error("stored row outside plot area");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> ((32'(wslot_q) < STORE_DEPTH) && (32'(newest_q) < STORE_DEPTH)))
		else $error("slot pointer beyond store depth");

endmodule

/* sv/scs_ctrl.sv */
// controller state machine sequencing init, push and draw operations
module scs_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic [scs_pkg::OP_W-1:0] s_tuser,
	output logic                     s_tready,
	input  scs_pkg::stat_t           st,
	output scs_pkg::cmd_t            cmd
);

	scs_pkg::state_t state_q;
	scs_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			scs_pkg::S_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						scs_pkg::OP_INIT: state_nxt = scs_pkg::S_INIT;
						scs_pkg::OP_PUSH: begin
							if (st.ready) state_nxt = scs_pkg::S_PMUL;
						end
						scs_pkg::OP_DRAW: begin
							if (st.ready) state_nxt = scs_pkg::S_DDIVS;
						end
						default: state_nxt = scs_pkg::S_IDLE;
					endcase
				end
			end
			scs_pkg::S_INIT: begin
				if (st.fill_last) state_nxt = scs_pkg::S_IDLE;
			end
			scs_pkg::S_PMUL: begin
				state_nxt = st.range_zero ? scs_pkg::S_PWR : scs_pkg::S_PDIVS;
			end
			scs_pkg::S_PDIVS: state_nxt = scs_pkg::S_PDIV;
			scs_pkg::S_PDIV: begin
				if (!st.div_busy) state_nxt = scs_pkg::S_PWR;
			end
			scs_pkg::S_PWR:   state_nxt = scs_pkg::S_IDLE;
			scs_pkg::S_DDIVS: state_nxt = scs_pkg::S_DDIV;
			scs_pkg::S_DDIV: begin
				if (!st.div_busy) state_nxt = scs_pkg::S_DSET;
			end
			scs_pkg::S_DSET:  state_nxt = scs_pkg::S_DRD;
			scs_pkg::S_DRD:   state_nxt = scs_pkg::S_DOUT;
			scs_pkg::S_DOUT: begin
				if (st.out_free) begin
					state_nxt = st.seg_last ? scs_pkg::S_IDLE : scs_pkg::S_DRD;
				end
			end
			default: state_nxt = scs_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			scs_pkg::S_IDLE: begin
				s_tready     = 1'b1;
				cmd.latch_in = s_tvalid;
				cmd.fill_clr = s_tvalid && (s_tuser == scs_pkg::OP_INIT);
			end
			scs_pkg::S_INIT: begin
				cmd.fill_wr   = 1'b1;
				cmd.init_done = st.fill_last;
			end
			scs_pkg::S_PMUL:  cmd.mul = 1'b1;
			scs_pkg::S_PDIVS: cmd.div_start = 1'b1;
			scs_pkg::S_PWR:   cmd.push_wr = 1'b1;
			scs_pkg::S_DDIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_draw  = 1'b1;
			end
			scs_pkg::S_DSET: begin
				cmd.draw_setup = 1'b1;
				cmd.rd_newest  = 1'b1;
			end
			scs_pkg::S_DRD:  cmd.rd_step = 1'b1;
			scs_pkg::S_DOUT: cmd.load_out = st.out_free;
			default: ;
		endcase
	end

endmodule

/* sv/scrolling_strip_chart_engine.sv */
// top level of the scrolling strip chart engine
// One item is taken at a time; s_tready is high only while the engine is idle, and a finished
// segment waits in the output register while the next item is accepted. With n the active
// count (sample_count held to [2, STORE_DEPTH]), an init writes the bottom row to each active
// ring entry, one per cycle. A push runs the 45-step restoring divider that forms
// (sample - min_value) * plot_height / (max_value - min_value); with equal limits it skips
// the divider. A draw first runs plot_width / n through the same divider, then reads the row
// store through its single registered read port and emits the segments one after another,
// each through a read state and then an output state that waits while the output register
// still holds a segment that m_tready has not taken.
// Push and draw before the first init are dropped without a result. The row store is not
// cleared at reset: entries that no init has written read back undefined.
module scrolling_strip_chart_engine #(
	parameter int STORE_DEPTH = scs_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scs_pkg::IDX_W-1:0]      cfg_index,
	input  logic [scs_pkg::VAL_W-1:0]      cfg_data,
	// item input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [scs_pkg::IN_DATA_W-1:0]  s_tdata,  // sample[31:0], color[63:32]
	input  logic [scs_pkg::OP_W-1:0]       s_tuser,  // op[1:0]
	// segment output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [scs_pkg::OUT_DATA_W-1:0] m_tdata,  // x_start[11:0], y_start[23:12],
	                                                 // x_end[35:24], y_end[47:36],
	                                                 // seg_color[79:48]
	output logic                           m_tlast   // last
);

	scs_pkg::cmd_t  cmd;
	scs_pkg::stat_t st;

	// registers accept a write in any cycle
	assign cfg_ready = 1'b1;

	scs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	scs_dp #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
